// ===== design/rzdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzdl_pkg
// Shared widths, register indexes, reset values and stage payload types for
// the reversed-Z depth linearizer.
// ----------------------------------------------------------------------------
package rzdl_pkg;

  localparam int RAW_W  = 26;   // Q2.24 signed depth sample
  localparam int CFG_W  = 24;   // Q16.8 metres
  localparam int NDC_W  = 25;   // Q1.24 in [0, 1.0]
  localparam int NUM_W  = 48;   // numerator / denominator width
  localparam int LIN_W  = 24;
  localparam int GRAY_W = 8;
  localparam int SCL_W  = 32;   // d * 255
  localparam int IDX_W  = 2;

  localparam logic [NDC_W-1:0] NDC_ONE = 25'h1000000;
  localparam logic [LIN_W-1:0] LIN_MAX = '1;

  localparam logic [IDX_W-1:0] REG_NEAR = 2'd0;
  localparam logic [IDX_W-1:0] REG_FAR  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX  = 2'd2;

  localparam logic [CFG_W-1:0] NEAR_RST = 24'd38;
  localparam logic [CFG_W-1:0] FAR_RST  = 24'd2560000;
  localparam logic [CFG_W-1:0] MAX_RST  = 24'd128000;

  typedef struct packed {
    logic vld;
    logic last;
    logic err;
  } rzdl_ctl_t;

  typedef struct packed {
    rzdl_ctl_t        ctl;
    logic             zero;
    logic             sat;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } rzdl_div_t;

  typedef struct packed {
    rzdl_ctl_t        ctl;
    logic [LIN_W-1:0] lin;
  } rzdl_lin_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic              err;
    logic [LIN_W-1:0]  lin;
    logic [GRAY_W-1:0] gray;
  } rzdl_res_t;

endpackage

// ===== design/reversed_z_depth_linearizer.sv =====
`timescale 1ns / 1ps
// Pipeline: 3 front stages, 24 linear-divider stages plus override stage,
//   9 gray stages, output reg. Throughput: one pixel per clock while the
//   skid register is empty; the one-bit-per-stage dividers are fully
//   pipelined and a skid register keeps in_ready registered.
// Reset: synchronous rst clears all valid bits and loads the clip and range
//   registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// reversed_z_depth_linearizer
// Converts reversed-Z depth samples to Q16.8 metres and an 8-bit gray level.
// ----------------------------------------------------------------------------
module reversed_z_depth_linearizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rzdl_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rzdl_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rzdl_pkg::RAW_W-1:0]  raw_depth,
  input  logic                               frame_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rzdl_pkg::LIN_W-1:0]         linear_depth,
  output logic [rzdl_pkg::GRAY_W-1:0]        gray_level,
  output logic                               range_error,
  output logic                               frame_end
);
  import rzdl_pkg::*;

  logic [CFG_W-1:0] near_m, far_m, max_range_m;
  logic             en, push, skid_vld;
  rzdl_div_t        div_in;
  rzdl_lin_t        lin_res;
  rzdl_res_t        res, out_res, skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_m      <= NEAR_RST;
      far_m       <= FAR_RST;
      max_range_m <= MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NEAR: near_m      <= cfg_wr_data;
        REG_FAR:  far_m       <= cfg_wr_data;
        REG_MAX:  max_range_m <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the skid register holds a result
  assign en       = !skid_vld;
  assign in_ready = en;
  assign push     = en && res.vld;

  rzdl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (in_valid),
    .raw_depth (raw_depth),
    .frame_last(frame_last),
    .near_dist (near_m),
    .far_dist  (far_m),
    .dout      (div_in)
  );

  rzdl_lin_div u_lin_div (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .din (div_in),
    .dout(lin_res)
  );

  rzdl_gray u_gray (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .din      (lin_res),
    .max_range(max_range_m),
    .dout     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_vld) begin
        out_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_vld) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= res;
      end
    end else if (push) begin
      skid_res <= res;
    end
  end

  assign linear_depth = out_res.lin;
  assign gray_level   = out_res.gray;
  assign range_error  = out_res.err;
  assign frame_end    = out_res.last;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid register holds a result while output is empty");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> linear_depth == '0 && gray_level == '0)
    else $error("range error transfer carries nonzero depth or gray");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== design/rzdl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzdl_front
// Three stages: ndc clamp and far*near, ndc*(far-near), then the
// denominator with the zero and saturation checks for the divider.
// ----------------------------------------------------------------------------
module rzdl_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [rzdl_pkg::RAW_W-1:0] raw_depth,
  input  logic                            frame_last,
  input  logic [rzdl_pkg::CFG_W-1:0]      near_dist,
  input  logic [rzdl_pkg::CFG_W-1:0]      far_dist,
  output rzdl_pkg::rzdl_div_t             dout
);
  import rzdl_pkg::*;

  rzdl_ctl_t        s1_ctl, s2_ctl, s3_ctl;
  logic [NDC_W-1:0] s1_ndc;
  logic [CFG_W-1:0] s1_diff;
  logic [NUM_W-1:0] s1_num, s2_num, s2_prod;
  logic [NDC_W-1:0] ndc_next;
  logic [NUM_W-1:0] den_next;
  logic             s3_zero, s3_sat;
  logic [NUM_W-1:0] s3_num, s3_den;

  // ndc = 1 - raw clamped to [0,1]
  always_comb begin
    if (raw_depth[RAW_W-1]) begin
      ndc_next = NDC_ONE;
    end else if (raw_depth[RAW_W-2]) begin
      ndc_next = '0;
    end else begin
      ndc_next = NDC_ONE - {1'b0, raw_depth[NDC_W-2:0]};
    end
  end

  assign den_next = {far_dist, {CFG_W{1'b0}}} - s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else if (en) begin
      s1_ctl <= '{vld: in_vld, last: frame_last, err: (far_dist <= near_dist)};
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ndc  <= ndc_next;
      s1_diff <= far_dist - near_dist;
      s1_num  <= NUM_W'(far_dist) * NUM_W'(near_dist);
      s2_prod <= NUM_W'(s1_ndc) * NUM_W'(s1_diff);
      s2_num  <= s1_num;
      s3_zero <= (s2_num == '0);
      s3_sat  <= (s2_num >= den_next);
      s3_num  <= s2_num;
      s3_den  <= den_next;
    end
  end

  always_comb begin
    dout.ctl  = s3_ctl;
    dout.zero = s3_zero;
    dout.sat  = s3_sat;
    dout.num  = s3_num;
    dout.den  = s3_den;
  end

endmodule

// ===== design/rzdl_lin_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzdl_lin_div
// Restoring divider, one quotient bit per stage, 24 stages, followed by the
// stage that applies error, zero and saturation overrides.
// ----------------------------------------------------------------------------
module rzdl_lin_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rzdl_pkg::rzdl_div_t din,
  output rzdl_pkg::rzdl_lin_t dout
);
  import rzdl_pkg::*;

  localparam int QBITS = LIN_W;

  rzdl_ctl_t        st_ctl  [QBITS];
  logic             st_zero [QBITS];
  logic             st_sat  [QBITS];
  logic [NUM_W-1:0] st_rem  [QBITS];
  logic [NUM_W-1:0] st_den  [QBITS];
  logic [LIN_W-1:0] st_q    [QBITS];

  rzdl_ctl_t        res_ctl;
  logic [LIN_W-1:0] res_lin;

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    rzdl_ctl_t        p_ctl;
    logic             p_zero, p_sat, take;
    logic [NUM_W-1:0] p_rem, p_den;
    logic [LIN_W-1:0] p_q;
    logic [NUM_W:0]   sh;

    if (k == 0) begin : g_first
      assign p_ctl  = din.ctl;
      assign p_zero = din.zero;
      assign p_sat  = din.sat;
      assign p_rem  = din.num;
      assign p_den  = din.den;
      assign p_q    = '0;
    end else begin : g_next
      assign p_ctl  = st_ctl[k-1];
      assign p_zero = st_zero[k-1];
      assign p_sat  = st_sat[k-1];
      assign p_rem  = st_rem[k-1];
      assign p_den  = st_den[k-1];
      assign p_q    = st_q[k-1];
    end

    assign sh   = {p_rem, 1'b0};
    assign take = (sh >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[k] <= '0;
      end else if (en) begin
        st_ctl[k] <= p_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_zero[k] <= p_zero;
        st_sat[k]  <= p_sat;
        st_den[k]  <= p_den;
        st_rem[k]  <= take ? NUM_W'(sh - {1'b0, p_den}) : sh[NUM_W-1:0];
        st_q[k]    <= {p_q[LIN_W-2:0], take};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl <= '0;
    end else if (en) begin
      res_ctl <= st_ctl[QBITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (st_ctl[QBITS-1].err || st_zero[QBITS-1]) begin
        res_lin <= '0;
      end else if (st_sat[QBITS-1]) begin
        res_lin <= LIN_MAX;
      end else begin
        res_lin <= st_q[QBITS-1];
      end
    end
  end

  always_comb begin
    dout.ctl = res_ctl;
    dout.lin = res_lin;
  end

endmodule

// ===== design/rzdl_gray.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzdl_gray
// Clamps depth to max range, forms d*255 and divides by max range with one
// quotient bit per stage (8 stages).
// ----------------------------------------------------------------------------
module rzdl_gray (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rzdl_pkg::rzdl_lin_t        din,
  input  logic [rzdl_pkg::CFG_W-1:0] max_range,
  output rzdl_pkg::rzdl_res_t        dout
);
  import rzdl_pkg::*;

  rzdl_ctl_t         g0_ctl;
  logic [LIN_W-1:0]  g0_lin;
  logic [SCL_W-1:0]  g0_rem;
  logic [LIN_W-1:0]  d_clamp;

  rzdl_ctl_t         st_ctl [GRAY_W];
  logic [LIN_W-1:0]  st_lin [GRAY_W];
  logic [SCL_W-1:0]  st_rem [GRAY_W];
  logic [GRAY_W-1:0] st_q   [GRAY_W];

  assign d_clamp = (din.lin > max_range) ? max_range : din.lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      g0_ctl <= '0;
    end else if (en) begin
      g0_ctl <= din.ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g0_lin <= din.lin;
      // d*255 = d*256 - d
      g0_rem <= {d_clamp, {GRAY_W{1'b0}}} - SCL_W'(d_clamp);
    end
  end

  for (genvar k = 0; k < GRAY_W; k++) begin : g_stage
    rzdl_ctl_t         p_ctl;
    logic [LIN_W-1:0]  p_lin;
    logic [SCL_W-1:0]  p_rem, dv;
    logic [GRAY_W-1:0] p_q;
    logic              take;

    if (k == 0) begin : g_first
      assign p_ctl = g0_ctl;
      assign p_lin = g0_lin;
      assign p_rem = g0_rem;
      assign p_q   = '0;
    end else begin : g_next
      assign p_ctl = st_ctl[k-1];
      assign p_lin = st_lin[k-1];
      assign p_rem = st_rem[k-1];
      assign p_q   = st_q[k-1];
    end

    // divisor aligned to quotient bit GRAY_W-1-k
    assign dv   = SCL_W'(max_range) << (GRAY_W - 1 - k);
    assign take = (p_rem >= dv);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_ctl[k] <= '0;
      end else if (en) begin
        st_ctl[k] <= p_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_lin[k] <= p_lin;
        st_rem[k] <= take ? (p_rem - dv) : p_rem;
        st_q[k]   <= {p_q[GRAY_W-2:0], take};
      end
    end
  end

  always_comb begin
    dout.vld  = st_ctl[GRAY_W-1].vld;
    dout.last = st_ctl[GRAY_W-1].last;
    dout.err  = st_ctl[GRAY_W-1].err;
    dout.lin  = st_lin[GRAY_W-1];
    // zero max range would set every quotient bit
    dout.gray = (st_ctl[GRAY_W-1].err || max_range == '0) ? '0 : st_q[GRAY_W-1];
  end

endmodule
